/* sv/clnws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnws_pkg
// Shared types, codes and pin-state tables for the character LCD nibble
// write sequencer.
// ----------------------------------------------------------------------------
package clnws_pkg;

  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned HOLD_W      = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PULSE_W-1:0] PULSE_HOLD_RST = 16'd200;
  localparam logic [HOLD_W-1:0]  LONG_HOLD_RST  = 20'd100000;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd1;

  localparam logic [STEP_W-1:0] INIT_LAST  = 4'd14;
  localparam logic [STEP_W-1:0] CLEAR_LAST = 4'd8;
  localparam logic [STEP_W-1:0] BYTE_LAST  = 4'd3;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_CLEAR = 3'd1,
    REQ_MOVE  = 3'd2,
    REQ_DATA  = 3'd3,
    REQ_CMD   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_CLEAR,
    OP_BYTE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       rs;
  } cmd_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       en;
    logic       use_long;
  } pin_t;

  function automatic pin_t byte_pin(logic [7:0] data, logic [STEP_W-1:0] step);
    pin_t p;
    p.nib      = step[1] ? data[3:0] : data[7:4];
    p.en       = ~step[0];
    p.use_long = 1'b0;
    return p;
  endfunction

  function automatic pin_t init_pin(logic [STEP_W-1:0] step);
    pin_t p;
    p.en       = 1'b0;
    p.use_long = 1'b0;
    p.nib      = 4'h0;
    case (step)
      4'd0:  p.use_long = 1'b1;
      4'd1:  begin p.nib = 4'h2; p.en = 1'b1; end
      4'd2:  p.nib = 4'h2;
      4'd3:  begin p.nib = 4'h2; p.en = 1'b1; end
      4'd4:  p.nib = 4'h2;
      4'd5:  begin p.nib = 4'h8; p.en = 1'b1; end
      4'd6:  p.nib = 4'h8;
      4'd7:  p.en = 1'b1;
      4'd8:  p.nib = 4'h0;
      4'd9:  begin p.nib = 4'hC; p.en = 1'b1; end
      4'd10: p.nib = 4'hC;
      4'd11: p.en = 1'b1;
      4'd12: p.nib = 4'h0;
      4'd13: begin p.nib = 4'h6; p.en = 1'b1; end
      4'd14: p.nib = 4'h6;
      default: p.nib = 4'h0;
    endcase
    return p;
  endfunction

  function automatic pin_t clear_pin(logic [STEP_W-1:0] step);
    pin_t p;
    if (step == CLEAR_LAST) begin
      p.nib      = 4'h2;
      p.en       = 1'b0;
      p.use_long = 1'b1;
    end else if (step[2]) begin
      p = byte_pin(8'h02, step);
    end else begin
      p = byte_pin(8'h01, step);
    end
    return p;
  endfunction

endpackage

/* sv/char_lcd_nibble_write_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Character LCD 4-bit write sequencer: requests in, pin states out.
// ----------------------------------------------------------------------------
// A request (init, clear, cursor move, data character or command byte) is
// transferred on the input channel when in_valid_i is high and in_stall_o is
// low. Each request yields a run of pin states on the output channel, one per
// transfer, the final one flagged by last_o: 15 for init, 9 for clear and 4
// for the byte kinds. Unknown request kinds are taken and dropped.
// The front classifies a request in the cycle it is taken and queues it; the
// back pops it from the queue once idle and emits one pin state per cycle
// while the output is not stalled. Each request passes through the queue
// and the back's command register before its first state is registered.
// The configuration channel writes pulse_hold (index 0) and long_hold
// (index 1) and is always ready. Reset empties the queue, drops any output
// and restores the hold values to 200 and 100000. While out_stall_i
// is high the current state holds; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = clnws_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        req_type_i,
  input  logic                              row_i,
  input  logic [5:0]                        col_i,
  input  logic [7:0]                        byte_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [3:0]                        data_nibble_o,
  output logic                              reg_select_o,
  output logic                              enable_o,
  output logic [clnws_pkg::HOLD_W-1:0]      hold_cycles_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [clnws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [clnws_pkg::HOLD_W-1:0]      cfg_data_i
);

  logic [clnws_pkg::PULSE_W-1:0] pulse_hold_q, pulse_hold_d;
  logic [clnws_pkg::HOLD_W-1:0]  long_hold_q, long_hold_d;
  logic                          q_push, q_pop, q_full, q_empty;
  clnws_pkg::cmd_t               push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pulse_hold_d = pulse_hold_q;
    long_hold_d  = long_hold_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == clnws_pkg::CFG_PULSE_HOLD) begin
        pulse_hold_d = cfg_data_i[clnws_pkg::PULSE_W-1:0];
      end else if (cfg_index_i == clnws_pkg::CFG_LONG_HOLD) begin
        long_hold_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_hold_q <= clnws_pkg::PULSE_HOLD_RST;
      long_hold_q  <= clnws_pkg::LONG_HOLD_RST;
    end else begin
      pulse_hold_q <= pulse_hold_d;
      long_hold_q  <= long_hold_d;
    end
  end

  clnws_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .byte_value_i (byte_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  clnws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  clnws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pulse_hold_i  (pulse_hold_q),
    .long_hold_i   (long_hold_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_nibble_o (data_nibble_o),
    .reg_select_o  (reg_select_o),
    .enable_o      (enable_o),
    .hold_cycles_o (hold_cycles_o),
    .last_o        (last_o)
  );

endmodule

/* sv/clnws_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnws_front
// Accepts requests and turns each known kind into a queued command record.
// ----------------------------------------------------------------------------
module clnws_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            req_type_i,
  input  logic                  row_i,
  input  logic [5:0]            col_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output clnws_pkg::cmd_t       q_cmd_o
);

  logic known;

  always_comb begin
    known         = 1'b1;
    q_cmd_o.op    = clnws_pkg::OP_BYTE;
    q_cmd_o.data  = byte_value_i;
    q_cmd_o.rs    = 1'b0;
    unique case (req_type_i)
      clnws_pkg::REQ_INIT:  q_cmd_o.op = clnws_pkg::OP_INIT;
      clnws_pkg::REQ_CLEAR: q_cmd_o.op = clnws_pkg::OP_CLEAR;
      clnws_pkg::REQ_MOVE:  q_cmd_o.data = {1'b1, row_i, col_i};
      clnws_pkg::REQ_DATA:  q_cmd_o.rs = 1'b1;
      clnws_pkg::REQ_CMD:   q_cmd_o.rs = 1'b0;
      default:              known = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i & known;

endmodule

/* sv/clnws_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnws_queue
// Small register queue of command records between front and back.
// ----------------------------------------------------------------------------
module clnws_queue #(
  parameter int unsigned DEPTH = clnws_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clnws_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output clnws_pkg::cmd_t cmd_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  clnws_pkg::cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o   = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);

endmodule

/* sv/clnws_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnws_back
// Walks one command through its pin states, one state per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module clnws_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [clnws_pkg::PULSE_W-1:0]       pulse_hold_i,
  input  logic [clnws_pkg::HOLD_W-1:0]        long_hold_i,
  input  logic                                q_empty_i,
  input  clnws_pkg::cmd_t                     q_cmd_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [3:0]                          data_nibble_o,
  output logic                                reg_select_o,
  output logic                                enable_o,
  output logic [clnws_pkg::HOLD_W-1:0]        hold_cycles_o,
  output logic                                last_o
);

  logic                             busy_q, busy_d;
  logic [clnws_pkg::STEP_W-1:0]     step_q, step_d;
  clnws_pkg::cmd_t                  rec_q, rec_d;
  logic                             out_valid_q, out_valid_d;
  logic [3:0]                       nib_q, nib_d;
  logic                             rs_q, rs_d;
  logic                             en_q, en_d;
  logic [clnws_pkg::HOLD_W-1:0]     hold_q, hold_d;
  logic                             last_q, last_d;
  clnws_pkg::pin_t                  pin;
  logic [clnws_pkg::STEP_W-1:0]     last_step;
  logic                             is_last;
  logic                             advance;

  always_comb begin
    unique case (rec_q.op)
      clnws_pkg::OP_INIT: begin
        pin       = clnws_pkg::init_pin(step_q);
        last_step = clnws_pkg::INIT_LAST;
      end
      clnws_pkg::OP_CLEAR: begin
        pin       = clnws_pkg::clear_pin(step_q);
        last_step = clnws_pkg::CLEAR_LAST;
      end
      default: begin
        pin       = clnws_pkg::byte_pin(rec_q.data, step_q);
        last_step = clnws_pkg::BYTE_LAST;
      end
    endcase
    is_last = (step_q == last_step);
    advance = busy_q & (~out_valid_q | ~out_stall_i);
    q_pop_o = ~busy_q & ~q_empty_i;

    busy_d      = busy_q;
    step_d      = step_q;
    rec_d       = rec_q;
    out_valid_d = out_valid_q & out_stall_i;
    nib_d       = nib_q;
    rs_d        = rs_q;
    en_d        = en_q;
    hold_d      = hold_q;
    last_d      = last_q;

    if (q_pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
      rec_d  = q_cmd_i;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      nib_d       = pin.nib;
      rs_d        = (rec_q.op == clnws_pkg::OP_BYTE) ? rec_q.rs : 1'b0;
      en_d        = pin.en;
      hold_d      = pin.use_long ? long_hold_i
                                 : {{(clnws_pkg::HOLD_W - clnws_pkg::PULSE_W){1'b0}},
                                    pulse_hold_i};
      last_d      = is_last;
      step_d      = step_q + 1'b1;
      busy_d      = ~is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    nib_q  <= nib_d;
    rs_q   <= rs_d;
    en_q   <= en_d;
    hold_q <= hold_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign data_nibble_o = nib_q;
  assign reg_select_o  = rs_q;
  assign enable_o      = en_q;
  assign hold_cycles_o = hold_q;
  assign last_o        = last_q;

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= last_step)
    else $error("step counter ran past the end of the command");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> busy_q && step_q == '0)
    else $error("queue pop did not start a fresh command");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_last) |=> !busy_q && out_valid_q && last_q)
    else $error("final pin state did not release the sequencer");

endmodule
